>>> sv/mmric_pkg.sv
// ---------------------------------------------------------------------------
// mmric_pkg
// Shared types and constants for the masked mixed-radix index counter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mmric_pkg;

   // fixed field widths of the ports
   localparam int unsigned FIELD_W       = 16;
   localparam int unsigned NUM_PORT_DIMS = 4;
   localparam int unsigned ACTION_W      = 2;
   localparam int unsigned RANK_W        = 3;
   localparam int unsigned MASK_W        = 4;
   localparam int unsigned CSR_IDX_W     = 3;
   localparam int unsigned CSR_DATA_W    = 16;

   // commands
   localparam logic [ACTION_W-1:0] ACT_NEXT  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_PREV  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd3;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_RANK   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE0  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE1  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE2  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE3  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSED = 3'd5;

   localparam logic [RANK_W-1:0]  RANK_RESET = 3'd1;
   localparam logic [FIELD_W-1:0] SIZE_RESET = 16'd1;

   // carry/flag chain between neighboring cells
   typedef struct packed {
      logic carry;
      logic wrap;
      logic last;
      logic valid;
   } link_type;

   // command broadcast to every cell
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                use_closed;
      logic                step;
   } cmd_type;

   // per-dimension setup seen by one cell
   typedef struct packed {
      logic               used;
      logic               closed;
      logic               loadable;
      logic [FIELD_W-1:0] size;
      logic [FIELD_W-1:0] load_idx;
   } dim_cfg_type;

   // one result transaction
   typedef struct packed {
      logic [NUM_PORT_DIMS-1:0][FIELD_W-1:0] idx;
      logic                                  is_last;
      logic                                  is_valid;
      logic                                  wrapped;
   } result_type;

endpackage

`default_nettype wire

>>> sv/mmric_cell.sv
// ---------------------------------------------------------------------------
// mmric_cell
// One digit of the odometer: holds one index, takes the carry from the less
// significant neighbor and hands carry and summary flags to the next one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmric_cell #(
   parameter int unsigned INDEX_WIDTH = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire mmric_pkg::cmd_type        cmd,
   input  wire mmric_pkg::dim_cfg_type    dim,
   input  wire mmric_pkg::link_type       link_in,
   output mmric_pkg::link_type            link_out,
   output logic [INDEX_WIDTH-1:0]         next_idx
);

   localparam int unsigned CW =
      ((INDEX_WIDTH > mmric_pkg::FIELD_W) ? INDEX_WIDTH : mmric_pkg::FIELD_W) + 1;

   logic [INDEX_WIDTH-1:0] idx_ff;
   logic [INDEX_WIDTH-1:0] idx_in;

   logic [CW-1:0] v_ext;
   logic [CW-1:0] s_ext;
   logic [CW-1:0] inc_ext;
   logic [CW-1:0] dec_ext;
   logic [CW-1:0] lim_ext;
   logic [CW-1:0] nv_ext;
   logic          sel;
   logic          in_range;
   logic          at_top;
   logic          at_zero;
   logic          boundary;
   logic          hit;

   always_comb begin
      v_ext    = CW'(idx_ff);
      s_ext    = CW'(dim.size);
      inc_ext  = v_ext + CW'(1);
      dec_ext  = v_ext - CW'(1);
      lim_ext  = s_ext - CW'(1);
      sel      = dim.used & (dim.closed == cmd.use_closed);
      in_range = v_ext < s_ext;
      at_top   = inc_ext == s_ext;
      at_zero  = v_ext == '0;
      boundary = (cmd.action == mmric_pkg::ACT_NEXT) ? at_top : at_zero;
      hit      = link_in.carry & sel & in_range;

      idx_in = idx_ff;
      case (cmd.action)
         mmric_pkg::ACT_NEXT: begin
            if (hit) begin
               idx_in = at_top ? '0 : inc_ext[INDEX_WIDTH-1:0];
            end
         end
         mmric_pkg::ACT_PREV: begin
            if (hit) begin
               idx_in = at_zero ? lim_ext[INDEX_WIDTH-1:0] : dec_ext[INDEX_WIDTH-1:0];
            end
         end
         mmric_pkg::ACT_CLEAR: begin
            if (sel) begin
               idx_in = '0;
            end
         end
         mmric_pkg::ACT_LOAD: begin
            if (dim.used && dim.loadable) begin
               idx_in = INDEX_WIDTH'(dim.load_idx);
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
      if (!dim.used) begin
         idx_in = '0;
      end

      nv_ext = CW'(idx_in);

      // carry keeps moving past unselected digits and digits that rolled over;
      // an out-of-range digit kills it and flags the wrap
      link_out.carry = link_in.carry & (~sel | (in_range & boundary));
      link_out.wrap  = link_in.wrap | (link_in.carry & sel & ~in_range);
      link_out.last  = link_in.last & ~(sel & ((nv_ext + CW'(1)) != s_ext));
      link_out.valid = link_in.valid & ~(dim.used & (nv_ext >= s_ext));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.step) begin
         idx_ff <= idx_in;
      end
   end

   assign next_idx = idx_in;

endmodule

`default_nettype wire

>>> sv/masked_mixed_radix_index_counter_unit.sv
// ---------------------------------------------------------------------------
// masked_mixed_radix_index_counter_unit
// Multi-dimensional index counter: a row of digit cells steps the open or
// closed dimensions as an odometer, clears them or loads a tuple.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/ready    | action, use_closed, load_idx0..3
//  rsp     | out       | rsp_valid/ready    | idx0..3, is_last, is_valid, wrapped
//  csr     | in        | csr_we (no wait)   | csr_index, csr_wdata
//
//  One transaction per cycle while req_ready is high; its result is registered in the output or skid register.
//  The critical path is the carry ripple through MAX_DIMS cells followed by
//  the is_last / is_valid compares.
//  Reset loads rank 1, all sizes 1, closed mask 0 and a zero tuple; no
//  clearing pass, requests are taken as soon as reset is released.
//  A stalled result parks in a skid register; req_ready drops only when both
//  the output and skid registers are full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module masked_mixed_radix_index_counter_unit #(
   parameter int unsigned MAX_DIMS    = 4,
   parameter int unsigned INDEX_WIDTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,

   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [mmric_pkg::ACTION_W-1:0]        req_action,
   input  wire logic                                  req_use_closed,
   input  wire logic [mmric_pkg::FIELD_W-1:0]         req_load_idx0,
   input  wire logic [mmric_pkg::FIELD_W-1:0]         req_load_idx1,
   input  wire logic [mmric_pkg::FIELD_W-1:0]         req_load_idx2,
   input  wire logic [mmric_pkg::FIELD_W-1:0]         req_load_idx3,

   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [mmric_pkg::FIELD_W-1:0]              rsp_idx0,
   output logic [mmric_pkg::FIELD_W-1:0]              rsp_idx1,
   output logic [mmric_pkg::FIELD_W-1:0]              rsp_idx2,
   output logic [mmric_pkg::FIELD_W-1:0]              rsp_idx3,
   output logic                                       rsp_is_last,
   output logic                                       rsp_is_valid,
   output logic                                       rsp_wrapped,

   input  wire logic                                  csr_we,
   input  wire logic [mmric_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [mmric_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned NW = $clog2(MAX_DIMS + 1);

   // configuration
   logic [mmric_pkg::RANK_W-1:0]  rank_ff;
   logic [mmric_pkg::FIELD_W-1:0] size_ff [mmric_pkg::NUM_PORT_DIMS];
   logic [mmric_pkg::MASK_W-1:0]  closed_mask_ff;

   // output and skid stages
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   mmric_pkg::result_type  rsp_data_ff;
   mmric_pkg::result_type  rsp_data_in;
   logic                   skid_valid_ff;
   logic                   skid_valid_in;
   mmric_pkg::result_type  skid_data_ff;
   mmric_pkg::result_type  skid_data_in;

   logic                   accept;
   logic [NW-1:0]          used_dims;
   logic [mmric_pkg::FIELD_W-1:0] load_vec [mmric_pkg::NUM_PORT_DIMS];

   mmric_pkg::cmd_type     cmd;
   mmric_pkg::dim_cfg_type dim_cfg  [MAX_DIMS];
   mmric_pkg::link_type    link     [MAX_DIMS+1];
   logic [INDEX_WIDTH-1:0] next_idx [MAX_DIMS];
   mmric_pkg::result_type  result_in;

   assign req_ready = ~skid_valid_ff;
   assign accept    = req_valid & req_ready;

   assign load_vec[0] = req_load_idx0;
   assign load_vec[1] = req_load_idx1;
   assign load_vec[2] = req_load_idx2;
   assign load_vec[3] = req_load_idx3;

   // ---- configuration writes ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff        <= mmric_pkg::RANK_RESET;
         closed_mask_ff <= '0;
         for (int i = 0; i < int'(mmric_pkg::NUM_PORT_DIMS); i++) begin
            size_ff[i] <= mmric_pkg::SIZE_RESET;
         end
      end else if (csr_we) begin
         case (csr_index)
            mmric_pkg::CSR_RANK:   rank_ff        <= csr_wdata[mmric_pkg::RANK_W-1:0];
            mmric_pkg::CSR_SIZE0:  size_ff[0]     <= csr_wdata;
            mmric_pkg::CSR_SIZE1:  size_ff[1]     <= csr_wdata;
            mmric_pkg::CSR_SIZE2:  size_ff[2]     <= csr_wdata;
            mmric_pkg::CSR_SIZE3:  size_ff[3]     <= csr_wdata;
            mmric_pkg::CSR_CLOSED: closed_mask_ff <= csr_wdata[mmric_pkg::MASK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // rank 0 acts as 1, anything above the cell count is clamped
   always_comb begin
      if (rank_ff == '0) begin
         used_dims = NW'(1);
      end else if (int'(rank_ff) > int'(MAX_DIMS)) begin
         used_dims = NW'(MAX_DIMS);
      end else begin
         used_dims = NW'(rank_ff);
      end
   end

   assign cmd.action     = req_action;
   assign cmd.use_closed = req_use_closed;
   assign cmd.step       = accept;

   // carry enters at the least significant cell, only for counting
   assign link[MAX_DIMS].carry = (req_action == mmric_pkg::ACT_NEXT) ||
                                 (req_action == mmric_pkg::ACT_PREV);
   assign link[MAX_DIMS].wrap  = 1'b0;
   assign link[MAX_DIMS].last  = 1'b1;
   assign link[MAX_DIMS].valid = 1'b1;

   // ---- cell row ----
   for (genvar d = 0; d < MAX_DIMS; d++) begin : g_cell
      assign dim_cfg[d].used = NW'(d) < used_dims;
      if (d < mmric_pkg::NUM_PORT_DIMS) begin : g_cfg
         assign dim_cfg[d].closed   = closed_mask_ff[d];
         assign dim_cfg[d].loadable = 1'b1;
         assign dim_cfg[d].size     = size_ff[d];
         assign dim_cfg[d].load_idx = load_vec[d];
      end else begin : g_fixed
         assign dim_cfg[d].closed   = 1'b0;
         assign dim_cfg[d].loadable = 1'b0;
         assign dim_cfg[d].size     = mmric_pkg::SIZE_RESET;
         assign dim_cfg[d].load_idx = '0;
      end

      mmric_cell #(
         .INDEX_WIDTH (INDEX_WIDTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .dim      (dim_cfg[d]),
         .link_in  (link[d+1]),
         .link_out (link[d]),
         .next_idx (next_idx[d])
      );
   end

   for (genvar p = 0; p < mmric_pkg::NUM_PORT_DIMS; p++) begin : g_port
      if (p < MAX_DIMS) begin : g_live
         assign result_in.idx[p] = mmric_pkg::FIELD_W'(next_idx[p]);
      end else begin : g_zero
         assign result_in.idx[p] = '0;
      end
   end

   assign result_in.is_last  = link[0].last;
   assign result_in.is_valid = link[0].valid;
   assign result_in.wrapped  = link[0].wrap | link[0].carry;

   // ---- output register with skid ----
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result_in;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_idx0     = rsp_data_ff.idx[0];
   assign rsp_idx1     = rsp_data_ff.idx[1];
   assign rsp_idx2     = rsp_data_ff.idx[2];
   assign rsp_idx3     = rsp_data_ff.idx[3];
   assign rsp_is_last  = rsp_data_ff.is_last;
   assign rsp_is_valid = rsp_data_ff.is_valid;
   assign rsp_wrapped  = rsp_data_ff.wrapped;

`ifndef SYNTHESIS
   // skid only fills behind a held output
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds a transaction with the output empty");

   // a transaction taken while the output stalls must land in the skid
   a_stall_to_skid : assert property (@(posedge clock) disable iff (reset)
      (accept && rsp_valid_ff && !rsp_ready) |=> skid_valid_ff)
      else $error("transaction accepted under stall was dropped");

   // clear and load never report a wrap
   a_no_wrap_on_set : assert property (@(posedge clock) disable iff (reset)
      (req_action == mmric_pkg::ACT_CLEAR || req_action == mmric_pkg::ACT_LOAD)
      |-> !result_in.wrapped)
      else $error("wrap flagged on clear or load");
`endif

endmodule

`default_nettype wire

>>> tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the masked mixed-radix index counter. A directed
// table walks the reset state, the range extremes, every command and the
// corner cases. Random phases follow, each under a fresh setup of rank,
// extents and closed mask. Every transaction is predicted in-bench and each
// result is compared field by field, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int unsigned N_PHASES    = 14;
   localparam int unsigned PHASE_ITEMS = 100;
   localparam int unsigned HOLD_CYCLES = 50;
   localparam int unsigned STALL_LIMIT = 2000;

   typedef logic [0:mmric_pkg::NUM_PORT_DIMS-1][mmric_pkg::FIELD_W-1:0] tuple_type;

   typedef struct packed {
      logic [mmric_pkg::ACTION_W-1:0] action;
      logic                           use_closed;
      tuple_type                      load;
   } step_cmd_type;

   typedef struct packed {
      tuple_type idx;
      logic      last;
      logic      valid;
      logic      wrapped;
   } counter_rsp_type;

   typedef struct packed {
      logic                         set_cfg;
      logic [mmric_pkg::RANK_W-1:0] rank;
      tuple_type                    extent;
      logic [mmric_pkg::MASK_W-1:0] mask;
      step_cmd_type                 cmd;
      logic                         typed;
      counter_rsp_type              want;
   } dir_row_type;

   localparam tuple_type       ZERO4    = '0;
   localparam tuple_type       ONES4    = '1;
   localparam counter_rsp_type NO_CHECK = '0;
   localparam logic [15:0]     FULL     = 16'hFFFF;

   localparam int N_DIR = 24;
   localparam dir_row_type DIR_TBL [N_DIR] = '{
      // reset setup: rank 1, extent 1, all open
      '{1'b0, 3'd0, ZERO4, 4'd0, '{mmric_pkg::ACT_NEXT, 1'b0, ZERO4}, 1'b1,
        '{ZERO4, 1'b1, 1'b1, 1'b1}},
      '{1'b0, 3'd0, ZERO4, 4'd0, '{mmric_pkg::ACT_PREV, 1'b0, ZERO4}, 1'b1,
        '{ZERO4, 1'b1, 1'b1, 1'b1}},
      '{1'b0, 3'd0, ZERO4, 4'd0, '{mmric_pkg::ACT_LOAD, 1'b0, ONES4}, 1'b1,
        '{{FULL, 16'd0, 16'd0, 16'd0}, 1'b0, 1'b0, 1'b0}},
      '{1'b0, 3'd0, ZERO4, 4'd0, '{mmric_pkg::ACT_NEXT, 1'b0, ZERO4}, 1'b1,
        '{{FULL, 16'd0, 16'd0, 16'd0}, 1'b0, 1'b0, 1'b1}},
      '{1'b0, 3'd0, ZERO4, 4'd0, '{mmric_pkg::ACT_PREV, 1'b0, ZERO4}, 1'b1,
        '{{FULL, 16'd0, 16'd0, 16'd0}, 1'b0, 1'b0, 1'b1}},
      '{1'b0, 3'd0, ZERO4, 4'd0, '{mmric_pkg::ACT_CLEAR, 1'b0, ONES4}, 1'b1,
        '{ZERO4, 1'b1, 1'b1, 1'b0}},
      // nothing closed: stepping the closed class only wraps
      '{1'b0, 3'd0, ZERO4, 4'd0, '{mmric_pkg::ACT_NEXT, 1'b1, ZERO4}, 1'b1,
        '{ZERO4, 1'b1, 1'b1, 1'b1}},
      // four dims, dims 0 and 2 closed
      '{1'b1, 3'd4, {16'd3, 16'd1, 16'd2, FULL}, 4'b0101,
        '{mmric_pkg::ACT_LOAD, 1'b0, {16'd2, 16'd0, 16'd1, 16'hFFFE}}, 1'b1,
        '{{16'd2, 16'd0, 16'd1, 16'hFFFE}, 1'b1, 1'b1, 1'b0}},
      '{1'b0, 3'd0, ZERO4, 4'd0, '{mmric_pkg::ACT_NEXT, 1'b0, ZERO4}, 1'b0, NO_CHECK},
      '{1'b0, 3'd0, ZERO4, 4'd0, '{mmric_pkg::ACT_NEXT, 1'b1, ZERO4}, 1'b0, NO_CHECK},
      '{1'b0, 3'd0, ZERO4, 4'd0, '{mmric_pkg::ACT_PREV, 1'b1, ZERO4}, 1'b0, NO_CHECK},
      '{1'b0, 3'd0, ZERO4, 4'd0, '{mmric_pkg::ACT_PREV, 1'b0, ZERO4}, 1'b0, NO_CHECK},
      '{1'b0, 3'd0, ZERO4, 4'd0, '{mmric_pkg::ACT_CLEAR, 1'b1, ZERO4}, 1'b0, NO_CHECK},
      '{1'b0, 3'd0, ZERO4, 4'd0, '{mmric_pkg::ACT_PREV, 1'b1, ZERO4}, 1'b0, NO_CHECK},
      // rank 0 behaves as 1, full extents, all closed
      '{1'b1, 3'd0, ONES4, 4'hF,
        '{mmric_pkg::ACT_LOAD, 1'b1, {16'hFFFE, 16'd1, 16'd2, 16'd3}}, 1'b1,
        '{{16'hFFFE, 16'd0, 16'd0, 16'd0}, 1'b1, 1'b1, 1'b0}},
      '{1'b0, 3'd0, ZERO4, 4'd0, '{mmric_pkg::ACT_NEXT, 1'b1, ZERO4}, 1'b0, NO_CHECK},
      '{1'b0, 3'd0, ZERO4, 4'd0, '{mmric_pkg::ACT_NEXT, 1'b0, ZERO4}, 1'b0, NO_CHECK},
      // rank above the limit, zero extents mixed in
      '{1'b1, 3'd7, {16'd0, 16'd5, 16'd0, 16'd5}, 4'd0,
        '{mmric_pkg::ACT_LOAD, 1'b0, {16'd0, 16'd4, 16'd0, 16'd4}}, 1'b0, NO_CHECK},
      '{1'b0, 3'd0, ZERO4, 4'd0, '{mmric_pkg::ACT_NEXT, 1'b0, ZERO4}, 1'b0, NO_CHECK},
      '{1'b0, 3'd0, ZERO4, 4'd0, '{mmric_pkg::ACT_PREV, 1'b0, ZERO4}, 1'b0, NO_CHECK},
      '{1'b0, 3'd0, ZERO4, 4'd0, '{mmric_pkg::ACT_CLEAR, 1'b0, ZERO4}, 1'b0, NO_CHECK},
      '{1'b1, 3'd2, {16'd2, 16'd3, 16'd1, 16'd1}, 4'b0010,
        '{mmric_pkg::ACT_LOAD, 1'b1, {16'd1, 16'd2, 16'd0, 16'd0}}, 1'b0, NO_CHECK},
      '{1'b0, 3'd0, ZERO4, 4'd0, '{mmric_pkg::ACT_PREV, 1'b1, ZERO4}, 1'b0, NO_CHECK},
      '{1'b0, 3'd0, ZERO4, 4'd0, '{mmric_pkg::ACT_NEXT, 1'b1, ZERO4}, 1'b0, NO_CHECK}
   };

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [mmric_pkg::ACTION_W-1:0]   req_action = mmric_pkg::ACT_NEXT;
   logic                             req_use_closed = 1'b0;
   logic [mmric_pkg::FIELD_W-1:0]    req_load_idx0 = '0;
   logic [mmric_pkg::FIELD_W-1:0]    req_load_idx1 = '0;
   logic [mmric_pkg::FIELD_W-1:0]    req_load_idx2 = '0;
   logic [mmric_pkg::FIELD_W-1:0]    req_load_idx3 = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [mmric_pkg::FIELD_W-1:0]    rsp_idx0;
   logic [mmric_pkg::FIELD_W-1:0]    rsp_idx1;
   logic [mmric_pkg::FIELD_W-1:0]    rsp_idx2;
   logic [mmric_pkg::FIELD_W-1:0]    rsp_idx3;
   logic                             rsp_is_last;
   logic                             rsp_is_valid;
   logic                             rsp_wrapped;
   logic                             csr_we = 1'b0;
   logic [mmric_pkg::CSR_IDX_W-1:0]  csr_index = mmric_pkg::CSR_RANK;
   logic [mmric_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // counter copy kept by the bench
   logic [mmric_pkg::FIELD_W-1:0]    cur_tuple [mmric_pkg::NUM_PORT_DIMS];
   logic [mmric_pkg::FIELD_W-1:0]    dim_extent [mmric_pkg::NUM_PORT_DIMS];
   logic [mmric_pkg::RANK_W-1:0]     rank_reg;
   logic [mmric_pkg::MASK_W-1:0]     closed_reg;

   counter_rsp_type       pending_rsp [$];
   int unsigned           n_fail = 0;
   int unsigned           send_idle_pct = 34;
   int unsigned           recv_idle_pct = 65;
   logic                  hold_kick = 1'b0;
   logic                  hold_seen = 1'b0;
   int unsigned           hold_left = 0;
   int unsigned           quiet_cycles = 0;

   masked_mixed_radix_index_counter_unit i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit in_class(int d, logic cls);
      return closed_reg[d] == cls;
   endfunction

   // applies one command to the bench copy and returns the result it yields
   function automatic counter_rsp_type predict_step(step_cmd_type c);
      int              n;
      int              d;
      int unsigned     v;
      int unsigned     s;
      bit              stop;
      counter_rsp_type r;
      n = (rank_reg == 0) ? 1 :
          ((rank_reg > mmric_pkg::NUM_PORT_DIMS) ? mmric_pkg::NUM_PORT_DIMS : rank_reg);
      r = '0;
      stop = 1'b0;
      case (c.action)
         mmric_pkg::ACT_NEXT, mmric_pkg::ACT_PREV: begin
            r.wrapped = 1'b1;
            for (d = n - 1; d >= 0 && !stop; d--) begin
               v = cur_tuple[d];
               s = dim_extent[d];
               if (in_class(d, c.use_closed)) begin
                  if (v >= s) begin
                     // out of range: stop, lower updates stay
                     stop = 1'b1;
                  end else if (c.action == mmric_pkg::ACT_NEXT) begin
                     if (v + 1 < s) begin
                        cur_tuple[d] = mmric_pkg::FIELD_W'(v + 1);
                        r.wrapped = 1'b0;
                        stop = 1'b1;
                     end else begin
                        cur_tuple[d] = '0;
                     end
                  end else if (v > 0) begin
                     cur_tuple[d] = mmric_pkg::FIELD_W'(v - 1);
                     r.wrapped = 1'b0;
                     stop = 1'b1;
                  end else begin
                     cur_tuple[d] = mmric_pkg::FIELD_W'(s - 1);
                  end
               end
            end
         end
         mmric_pkg::ACT_CLEAR: begin
            for (d = 0; d < n; d++)
               if (in_class(d, c.use_closed)) cur_tuple[d] = '0;
         end
         mmric_pkg::ACT_LOAD: begin
            for (d = 0; d < n; d++) cur_tuple[d] = c.load[d];
         end
         default: begin
         end
      endcase
      r.last = 1'b1;
      r.valid = 1'b1;
      for (d = 0; d < mmric_pkg::NUM_PORT_DIMS; d++) begin
         if (d >= n) begin
            cur_tuple[d] = '0;
         end else begin
            v = cur_tuple[d];
            if (v >= dim_extent[d]) r.valid = 1'b0;
            if (in_class(d, c.use_closed) && v + 1 != dim_extent[d]) r.last = 1'b0;
         end
         r.idx[d] = cur_tuple[d];
      end
      return r;
   endfunction

   function automatic logic [mmric_pkg::FIELD_W-1:0] pick_extent();
      int unsigned p;
      p = $urandom_range(99);
      if (p < 4) return '0;
      if (p < 14) return 16'd1;
      if (p < 60) return mmric_pkg::FIELD_W'($urandom_range(2, 6));
      if (p < 75) return FULL;
      if (p < 85) return mmric_pkg::FIELD_W'($urandom_range(7, 300));
      return mmric_pkg::FIELD_W'($urandom_range(16'hFFFF));
   endfunction

   function automatic logic [mmric_pkg::FIELD_W-1:0] pick_index(
      logic [mmric_pkg::FIELD_W-1:0] ext);
      int unsigned p;
      p = $urandom_range(99);
      if (p < 50 && ext != 0) return mmric_pkg::FIELD_W'($urandom_range(ext - 16'd1));
      if (p < 65) return ext - 16'd1;
      if (p < 75) return '0;
      if (p < 85) return FULL;
      return mmric_pkg::FIELD_W'($urandom_range(16'hFFFF));
   endfunction

   function automatic step_cmd_type random_cmd();
      step_cmd_type c;
      int unsigned  p;
      p = $urandom_range(99);
      if (p < 40) c.action = mmric_pkg::ACT_NEXT;
      else if (p < 70) c.action = mmric_pkg::ACT_PREV;
      else if (p < 80) c.action = mmric_pkg::ACT_CLEAR;
      else c.action = mmric_pkg::ACT_LOAD;
      c.use_closed = 1'($urandom_range(1));
      for (int d = 0; d < mmric_pkg::NUM_PORT_DIMS; d++)
         c.load[d] = pick_index(dim_extent[d]);
      return c;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         n_fail++;
      end
   endtask

   // one transaction on the request side; the result is predicted on acceptance
   task automatic offer(step_cmd_type c, logic typed, counter_rsp_type want);
      counter_rsp_type model_rsp;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= c.action;
      req_use_closed <= c.use_closed;
      req_load_idx0  <= c.load[0];
      req_load_idx1  <= c.load[1];
      req_load_idx2  <= c.load[2];
      req_load_idx3  <= c.load[3];
      do @(posedge clock); while (!req_ready);
      model_rsp = predict_step(c);
      pending_rsp.push_back(typed ? want : model_rsp);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [mmric_pkg::CSR_IDX_W-1:0] idx,
                            logic [mmric_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         mmric_pkg::CSR_RANK:   rank_reg = data[mmric_pkg::RANK_W-1:0];
         mmric_pkg::CSR_SIZE0, mmric_pkg::CSR_SIZE1, mmric_pkg::CSR_SIZE2,
         mmric_pkg::CSR_SIZE3:  dim_extent[idx - mmric_pkg::CSR_SIZE0] = data;
         mmric_pkg::CSR_CLOSED: closed_reg = data[mmric_pkg::MASK_W-1:0];
         default: ; // unmapped index, ignored by the block
      endcase
   endtask

   task automatic program_counter(logic [mmric_pkg::CSR_DATA_W-1:0] rank_data,
                                  tuple_type ext,
                                  logic [mmric_pkg::CSR_DATA_W-1:0] mask_data, bit spare);
      wait_drained();
      repeat (2) @(posedge clock);
      write_reg(mmric_pkg::CSR_RANK, rank_data);
      write_reg(mmric_pkg::CSR_SIZE0, ext[0]);
      write_reg(mmric_pkg::CSR_SIZE1, ext[1]);
      write_reg(mmric_pkg::CSR_SIZE2, ext[2]);
      write_reg(mmric_pkg::CSR_SIZE3, ext[3]);
      write_reg(mmric_pkg::CSR_CLOSED, mask_data);
      if (spare)
         write_reg(mmric_pkg::CSR_CLOSED + mmric_pkg::CSR_IDX_W'($urandom_range(1, 2)),
                   mmric_pkg::CSR_DATA_W'($urandom));
      csr_we <= 1'b0;
   endtask

   // response side: random backpressure plus one long hold on request
   always @(posedge clock) begin : rsp_side
      counter_rsp_type want;
      counter_rsp_type got;
      if (rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("result transaction with nothing outstanding");
            n_fail++;
         end else begin
            want = pending_rsp.pop_front();
            got  = '{{rsp_idx0, rsp_idx1, rsp_idx2, rsp_idx3},
                     rsp_is_last, rsp_is_valid, rsp_wrapped};
            for (int d = 0; d < mmric_pkg::NUM_PORT_DIMS; d++)
               check_field($sformatf("idx%0d", d), want.idx[d], got.idx[d]);
            check_field("is_last", want.last, got.last);
            check_field("is_valid", want.valid, got.valid);
            check_field("wrapped", want.wrapped, got.wrapped);
         end
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_kick != hold_seen) begin
         hold_seen <= hold_kick;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      tuple_type                        ext;
      logic [mmric_pkg::CSR_DATA_W-1:0] rank_data;
      logic [mmric_pkg::CSR_DATA_W-1:0] mask_data;
      for (int d = 0; d < mmric_pkg::NUM_PORT_DIMS; d++) begin
         cur_tuple[d]  = '0;
         dim_extent[d] = mmric_pkg::SIZE_RESET;
      end
      rank_reg   = mmric_pkg::RANK_RESET;
      closed_reg = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (DIR_TBL[r]) begin
         if (DIR_TBL[r].set_cfg)
            program_counter(mmric_pkg::CSR_DATA_W'(DIR_TBL[r].rank), DIR_TBL[r].extent,
                            mmric_pkg::CSR_DATA_W'(DIR_TBL[r].mask), 1'b0);
         offer(DIR_TBL[r].cmd, DIR_TBL[r].typed, DIR_TBL[r].want);
      end

      for (int phase = 0; phase < N_PHASES; phase++) begin
         if (phase == N_PHASES / 3) begin
            send_idle_pct = 65;
            recv_idle_pct = 34;
         end else if (phase == 2 * N_PHASES / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         rank_data = mmric_pkg::CSR_DATA_W'($urandom);
         mask_data = mmric_pkg::CSR_DATA_W'($urandom);
         for (int d = 0; d < mmric_pkg::NUM_PORT_DIMS; d++) ext[d] = pick_extent();
         // a few fixed corners: all extents 1, all extents full, all closed
         if (phase == 1) begin
            rank_data[mmric_pkg::RANK_W-1:0] = 3'd4;
            ext = {16'd1, 16'd1, 16'd1, 16'd1};
         end else if (phase == 3) begin
            rank_data[mmric_pkg::RANK_W-1:0] = 3'd4;
            mask_data[mmric_pkg::MASK_W-1:0] = '0;
            ext = ONES4;
         end else if (phase == 4) begin
            mask_data[mmric_pkg::MASK_W-1:0] = '1;
         end
         program_counter(rank_data, ext, mask_data, 1'($urandom_range(1)));
         if (phase == 2 || phase == 11) hold_kick <= ~hold_kick;
         repeat (PHASE_ITEMS) offer(random_cmd(), 1'b0, NO_CHECK);
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (n_fail == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> masked_mixed_radix_index_counter_unit.f
sv/mmric_pkg.sv
sv/mmric_cell.sv
sv/masked_mixed_radix_index_counter_unit.sv
tb/tb.sv
